// File: rtl/core/lpc_pkg.sv
// ---------------------------------------------------------------------------
// Latch pulse controller package
// Shared item types, register indexes and reset values for the controller.
// ---------------------------------------------------------------------------
package lpc_pkg;

  // Width of the tick counters and their saturation value.
  localparam int unsigned CntW = 17;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register reset values.
  localparam logic [15:0] PulseMsRst = 16'd500;
  localparam logic [15:0] RestMsRst  = 16'd1000;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PULSE_MS        = 3'd0,
    REG_REST_MS         = 3'd1,
    REG_HAS_SENSOR      = 3'd2,
    REG_INVERT_ACTUATOR = 3'd3,
    REG_INVERT_SENSOR   = 3'd4
  } cfg_reg_e;

  // One millisecond tick item.
  typedef struct packed {
    logic cmd_valid;
    logic cmd_open;
    logic sensor_level;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic actuator_level;
    logic pulse_active;
    logic want_open;
  } out_item_t;

endpackage

// File: rtl/core/lpc_intf.sv
// ---------------------------------------------------------------------------
// Latch pulse controller channels
// Valid/ready channels for tick items, result items and register writes.
// ---------------------------------------------------------------------------
interface lpc_in_if;
  logic               valid;
  logic               ready;
  lpc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lpc_out_if;
  logic               valid;
  logic               ready;
  lpc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lpc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lpc_pkg::CfgIdxW-1:0]   idx;
  logic [lpc_pkg::CfgDataW-1:0]  data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

// File: rtl/core/latch_pulse_controller_unit.sv
// ---------------------------------------------------------------------------
// Latch pulse controller
// Drives a solenoid latch actuator from lock/unlock commands and a sensor.
// ---------------------------------------------------------------------------
// Each accepted input transfer is one millisecond tick and produces exactly
// one result transfer. The block takes one tick per clock cycle while the
// output is not stalled. A tick is held in an input register, and the
// controller state and the result register are updated from it once the
// result register is free or being taken; the result is then offered from
// the result register. The rate is set by the single state update per tick.
// Registers are written through the configuration channel, which
// is always ready; write them only while no tick is in flight.
module latch_pulse_controller_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  lpc_in_if.sink       in_i,
  lpc_out_if.source    out_o,
  lpc_cfg_if.sink      cfg_i
);

  // Configuration registers.
  logic [15:0] pulse_ms_q, rest_ms_q;
  logic        has_sensor_q, inv_act_q, inv_sens_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_ms_q   <= lpc_pkg::PulseMsRst;
      rest_ms_q    <= lpc_pkg::RestMsRst;
      has_sensor_q <= 1'b0;
      inv_act_q    <= 1'b0;
      inv_sens_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.idx)
        lpc_pkg::REG_PULSE_MS:        pulse_ms_q   <= cfg_i.data;
        lpc_pkg::REG_REST_MS:         rest_ms_q    <= cfg_i.data;
        lpc_pkg::REG_HAS_SENSOR:      has_sensor_q <= cfg_i.data[0];
        lpc_pkg::REG_INVERT_ACTUATOR: inv_act_q    <= cfg_i.data[0];
        lpc_pkg::REG_INVERT_SENSOR:   inv_sens_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Input register and pipeline flow control.
  logic              in_vld_q;
  lpc_pkg::in_item_t in_q;
  logic              step;

  assign step       = in_vld_q && (!out_o.valid || out_o.ready);
  assign in_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  // Controller state.
  logic                     open_wanted_q, open_wanted_d;
  logic                     pulse_needed_q, pulse_needed_d;
  logic                     pulsing_q, pulsing_d;
  logic [lpc_pkg::CntW-1:0] elapsed_q, elapsed_d;
  logic [lpc_pkg::CntW-1:0] since_q, since_d;
  logic                     pend_vld_q, pend_vld_d;
  logic                     pend_open_q, pend_open_d;

  // Per-tick update of the controller state.
  logic                     closed;
  logic                     done;
  logic                     need;
  logic [lpc_pkg::CntW-1:0] since_inc;

  always_comb begin
    closed    = (in_q.sensor_level == inv_sens_q);
    since_inc = (since_q == lpc_pkg::CntMax) ? since_q : since_q + 1'b1;

    open_wanted_d  = open_wanted_q;
    pulse_needed_d = pulse_needed_q;
    pulsing_d      = pulsing_q;
    elapsed_d      = elapsed_q;
    since_d        = since_inc;
    pend_vld_d     = pend_vld_q;
    pend_open_d    = pend_open_q;
    done           = 1'b0;
    need           = pulse_needed_q;

    if (pulsing_q) begin
      // A command during a pulse waits; the latest one wins.
      if (in_q.cmd_valid) begin
        pend_vld_d  = 1'b1;
        pend_open_d = in_q.cmd_open;
      end
      elapsed_d = (elapsed_q == lpc_pkg::CntMax) ? elapsed_q : elapsed_q + 1'b1;
      done = (has_sensor_q && !closed) || (elapsed_d > {1'b0, pulse_ms_q});
      if (done) begin
        pulsing_d = 1'b0;
        if (pend_vld_d) begin
          open_wanted_d  = pend_open_d;
          pulse_needed_d = pend_open_d;
          pend_vld_d     = 1'b0;
        end
      end
    end else begin
      if (in_q.cmd_valid) begin
        open_wanted_d = in_q.cmd_open;
        need          = in_q.cmd_open;
      end
      // With a sensor, an open request re-pulses while the latch reads closed.
      if (has_sensor_q && open_wanted_d) begin
        need = closed;
      end
      pulse_needed_d = need;
      if (need && (since_inc > {1'b0, rest_ms_q})) begin
        pulsing_d      = 1'b1;
        elapsed_d      = '0;
        since_d        = '0;
        pulse_needed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_wanted_q  <= 1'b0;
      pulse_needed_q <= 1'b0;
      pulsing_q      <= 1'b0;
      elapsed_q      <= '0;
      since_q        <= '0;
      pend_vld_q     <= 1'b0;
      pend_open_q    <= 1'b0;
    end else if (step) begin
      open_wanted_q  <= open_wanted_d;
      pulse_needed_q <= pulse_needed_d;
      pulsing_q      <= pulsing_d;
      elapsed_q      <= elapsed_d;
      since_q        <= since_d;
      pend_vld_q     <= pend_vld_d;
      pend_open_q    <= pend_open_d;
    end
  end

  // Result register.
  logic               out_vld_q;
  lpc_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.actuator_level <= pulsing_d ^ inv_act_q;
      out_q.pulse_active   <= pulsing_d;
      out_q.want_open      <= open_wanted_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

// File: bench/tb.sv
// ---------------------------------------------------------------------------
// Latch pulse controller testbench
// Drives millisecond ticks into the controller and checks every result
// transfer against a cycle-free model of the latch state, across register
// settings, sensor behavior and random handshake stalls on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  // Cycles to let pass after the last result before touching registers.
  localparam int unsigned DrainCycles = 6;
  // Register indexes from this value up are not implemented.
  localparam int unsigned NumRegs = 5;
  // Random settings per stall profile and ticks per setting.
  localparam int unsigned SettingsPerPhase = 4;
  localparam int unsigned TicksPerSetting  = 154;

  logic clk_i = 1'b0;
  logic rst_ni;

  lpc_in_if  in_ch ();
  lpc_out_if out_ch ();
  lpc_cfg_if cfg_ch ();

  latch_pulse_controller_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Clock with an 8 ns period.
  always #4 clk_i = ~clk_i;

  // Stall profile, in percent of cycles spent idle.
  int unsigned src_idle_pct = 20;
  int unsigned snk_idle_pct = 20;

  // Register copies kept by the model.
  logic [15:0] cfg_pulse_ms   = lpc_pkg::PulseMsRst;
  logic [15:0] cfg_rest_ms    = lpc_pkg::RestMsRst;
  logic        cfg_has_sensor = 1'b0;
  logic        cfg_inv_act    = 1'b0;
  logic        cfg_inv_sensor = 1'b0;

  // Latch state kept by the model.
  logic                     open_wanted  = 1'b0;
  logic                     pulse_needed = 1'b0;
  logic                     pulsing      = 1'b0;
  logic [lpc_pkg::CntW-1:0] pulse_cnt    = '0;
  logic [lpc_pkg::CntW-1:0] since_start  = '0;
  logic                     pend_valid   = 1'b0;
  logic                     pend_open    = 1'b0;

  // Sensor level the random stimulus currently presents.
  logic sensor_now = 1'b0;

  lpc_pkg::out_item_t expected_results[$];
  lpc_pkg::out_item_t want_res;

  int unsigned n_sent    = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors  = 0;
  int unsigned n_pulses  = 0;
  int unsigned n_cmds    = 0;
  int unsigned n_writes  = 0;

  // Advances the latch state by one tick and returns the result it causes.
  function automatic lpc_pkg::out_item_t advance_latch(lpc_pkg::in_item_t t);
    logic               closed;
    logic               done;
    lpc_pkg::out_item_t r;
    closed = (t.sensor_level == cfg_inv_sensor);
    if (since_start != lpc_pkg::CntMax) since_start++;
    if (pulsing) begin
      // Commands during a pulse wait; the latest one wins.
      if (t.cmd_valid) begin
        pend_valid = 1'b1;
        pend_open  = t.cmd_open;
      end
      if (pulse_cnt != lpc_pkg::CntMax) pulse_cnt++;
      done = (cfg_has_sensor && !closed) || (pulse_cnt > {1'b0, cfg_pulse_ms});
      if (done) begin
        pulsing = 1'b0;
        if (pend_valid) begin
          open_wanted  = pend_open;
          pulse_needed = pend_open;
          pend_valid   = 1'b0;
        end
      end
    end else begin
      if (t.cmd_valid) begin
        open_wanted  = t.cmd_open;
        pulse_needed = t.cmd_open;
      end
      // A fitted sensor asks for a new pulse whenever an unlocked latch is closed.
      if (cfg_has_sensor && open_wanted) pulse_needed = closed;
      if (pulse_needed && since_start > {1'b0, cfg_rest_ms}) begin
        pulsing      = 1'b1;
        pulse_cnt    = '0;
        since_start  = '0;
        pulse_needed = 1'b0;
        n_pulses++;
      end
    end
    r.actuator_level = pulsing ^ cfg_inv_act;
    r.pulse_active   = pulsing;
    r.want_open      = open_wanted;
    return r;
  endfunction

  // Mirrors one register write into the model; unknown indexes change nothing.
  function automatic void apply_reg(logic [lpc_pkg::CfgIdxW-1:0]  idx,
                                    logic [lpc_pkg::CfgDataW-1:0] data);
    unique case (idx)
      lpc_pkg::REG_PULSE_MS:        cfg_pulse_ms   = data;
      lpc_pkg::REG_REST_MS:         cfg_rest_ms    = data;
      lpc_pkg::REG_HAS_SENSOR:      cfg_has_sensor = data[0];
      lpc_pkg::REG_INVERT_ACTUATOR: cfg_inv_act    = data[0];
      lpc_pkg::REG_INVERT_SENSOR:   cfg_inv_sensor = data[0];
      default: ;
    endcase
  endfunction

  // Builds one random tick that mostly behaves like a real latch.
  function automatic lpc_pkg::in_item_t random_tick();
    lpc_pkg::in_item_t t;
    t.cmd_valid = ($urandom_range(99) < 12);
    t.cmd_open  = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) begin
      sensor_now = ~sensor_now;
    end else if (pulsing && $urandom_range(2) == 0) begin
      sensor_now = ~cfg_inv_sensor;
    end else if (!pulsing && $urandom_range(4) == 0) begin
      sensor_now = cfg_inv_sensor;
    end
    t.sensor_level = sensor_now;
    return t;
  endfunction

  // Predicts each accepted tick and checks each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(advance_latch(in_ch.data));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no tick waiting: %b", out_ch.data);
          n_errors++;
        end else begin
          want_res = expected_results.pop_front();
          if (out_ch.data.actuator_level !== want_res.actuator_level) begin
            $error("actuator_level: expected %0b, got %0b",
                   want_res.actuator_level, out_ch.data.actuator_level);
            n_errors++;
          end
          if (out_ch.data.pulse_active !== want_res.pulse_active) begin
            $error("pulse_active: expected %0b, got %0b",
                   want_res.pulse_active, out_ch.data.pulse_active);
            n_errors++;
          end
          if (out_ch.data.want_open !== want_res.want_open) begin
            $error("want_open: expected %0b, got %0b",
                   want_res.want_open, out_ch.data.want_open);
            n_errors++;
          end
        end
        n_checked++;
      end
    end
  end

  // The result side stalls at random according to the current profile.
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Sends one tick; valid stays high afterwards so ticks can go back to back.
  task automatic send_tick(logic cv, logic co, logic lvl);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid             <= 1'b1;
    in_ch.data.cmd_valid    <= cv;
    in_ch.data.cmd_open     <= co;
    in_ch.data.sensor_level <= lvl;
    do @(posedge clk_i); while (!in_ch.ready);
    n_sent++;
    if (cv) n_cmds++;
  endtask

  // Stops sending and waits until every tick has produced its result.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (n_checked < n_sent) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register write transfer, after which the channel goes idle.
  task automatic write_reg(logic [lpc_pkg::CfgIdxW-1:0]  idx,
                           logic [lpc_pkg::CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    apply_reg(idx, data);
    n_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // The first pulse after reset must wait out the rest time.
  task automatic test_first_pulse();
    write_reg(lpc_pkg::REG_REST_MS, 16'd3);
    write_reg(lpc_pkg::REG_PULSE_MS, 16'd1);
    send_tick(1'b1, 1'b1, 1'b0);
    repeat (5) send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);
    settle();
  endtask

  // With a zero pulse length the pulse lasts for its start tick only.
  task automatic test_zero_pulse();
    write_reg(lpc_pkg::REG_PULSE_MS, 16'd0);
    write_reg(lpc_pkg::REG_REST_MS, 16'd0);
    write_reg(lpc_pkg::REG_INVERT_ACTUATOR, 16'hA5A5);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    settle();
    write_reg(lpc_pkg::REG_INVERT_ACTUATOR, 16'hFFFE);
  endtask

  // Sensor ends a pulse early, re-pulses a closed latch, and pending commands.
  task automatic test_sensor_path();
    write_reg(lpc_pkg::REG_HAS_SENSOR, 16'h0001);
    write_reg(lpc_pkg::REG_INVERT_SENSOR, 16'h0000);
    write_reg(lpc_pkg::REG_PULSE_MS, 16'd5);
    write_reg(lpc_pkg::REG_REST_MS, 16'd2);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    repeat (4) send_tick(1'b0, 1'b0, 1'b0);
    settle();
    write_reg(lpc_pkg::REG_INVERT_SENSOR, 16'h8001);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    settle();
  endtask

  // Writes to unimplemented indexes must leave every register alone.
  task automatic test_unused_index();
    for (int unsigned i = NumRegs; i < (1 << lpc_pkg::CfgIdxW); i++) begin
      write_reg(i[lpc_pkg::CfgIdxW-1:0], 16'($urandom()));
    end
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
    settle();
  endtask

  // Largest and smallest lengths; the last pulse keeps running into the next test.
  task automatic test_extreme_registers();
    write_reg(lpc_pkg::REG_HAS_SENSOR, 16'h0000);
    write_reg(lpc_pkg::REG_PULSE_MS, 16'hFFFF);
    write_reg(lpc_pkg::REG_REST_MS, 16'hFFFF);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    settle();
    write_reg(lpc_pkg::REG_REST_MS, 16'h0000);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    settle();
  endtask

  // Random ticks over several random settings with one stall profile.
  task automatic test_random_traffic(int unsigned src_pct, int unsigned snk_pct);
    lpc_pkg::in_item_t t;
    int unsigned       pick;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int unsigned s = 0; s < SettingsPerPhase; s++) begin
      settle();
      pick = $urandom_range(19);
      write_reg(lpc_pkg::REG_PULSE_MS,
                (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                (pick == 2) ? lpc_pkg::PulseMsRst : 16'($urandom_range(12, 1)));
      pick = $urandom_range(19);
      write_reg(lpc_pkg::REG_REST_MS,
                (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                (pick == 2) ? lpc_pkg::RestMsRst : 16'($urandom_range(25)));
      write_reg(lpc_pkg::REG_HAS_SENSOR, 16'($urandom()));
      write_reg(lpc_pkg::REG_INVERT_ACTUATOR, 16'($urandom()));
      write_reg(lpc_pkg::REG_INVERT_SENSOR, 16'($urandom()));
      for (int unsigned k = 0; k < TicksPerSetting; k++) begin
        // Now and then hold off until the block has nothing in flight.
        if ($urandom_range(59) == 0) settle();
        t = random_tick();
        send_tick(t.cmd_valid, t.cmd_open, t.sensor_level);
      end
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.idx   <= '0;
    cfg_ch.data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_pulse();
    test_zero_pulse();
    test_sensor_path();
    test_unused_index();
    test_extreme_registers();
    test_random_traffic(11, 79);
    test_random_traffic(79, 11);
    test_random_traffic(0, 0);

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      n_errors++;
    end
    $display("Checked %0d ticks carrying %0d commands, with %0d pulses predicted",
             n_checked, n_cmds, n_pulses);
    $display("across %0d register writes and three stall profiles", n_writes);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lpc_pkg.sv
rtl/core/lpc_intf.sv
rtl/core/latch_pulse_controller_unit.sv
bench/tb.sv
